// ----- rtl/mer_pkg.sv -----
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by the channel interfaces, the sequencer, the multiplier and the top level.
package mer_pkg;

	// Field widths fixed by the channel format
	localparam int AXIS_BITS_DEF = 9;
	localparam int CENTER_W      = 11;
	localparam int SEMI_W        = 9;
	localparam int COLOR_W       = 24;
	localparam int COORD_W       = 13;
	localparam int ORIGIN_W      = 11;
	localparam int CFG_IDX_W     = 2;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [ORIGIN_W-1:0]  ORIGIN_X_RST = 11'd640;
	localparam logic [ORIGIN_W-1:0]  ORIGIN_Y_RST = 11'd480;

	// Item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [1:0] {
		RGN_ONE  = 2'd0,
		RGN_TWO  = 2'd1,
		RGN_DONE = 2'd2
	} region_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQA, ST_SQB, ST_INI1, ST_INI2, ST_INI3,
		ST_R1A, ST_R1B, ST_R1C, ST_R2A, ST_R2B, ST_R2C,
		ST_CHK1, ST_CHK2, ST_CHK3,
		ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6,
		ST_TRUNC, ST_YCHK, ST_EMIT
	} state_t;

	// Operand pair routed into the shared multiplier
	typedef enum logic [3:0] {
		MS_AA, MS_BB, MS_A2_INIT, MS_B2_X3, MS_A2_2Y, MS_A2_3Y, MS_B2_X2,
		MS_B2_X, MS_A2_Y, MS_TX2, MS_TY2, MS_B2_SQ, MS_A2_SQ, MS_A2_B2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD, ACC_INIT, ACC_LOAD, ACC_LOAD_RND, ACC_ADD4, ACC_SUB4
	} acc_op_t;

	typedef enum logic [1:0] {
		DEC_HOLD, DEC_ADD, DEC_ADD_IF, DEC_TRUNC
	} dec_op_t;

	typedef enum logic [1:0] {
		STEP_HOLD, STEP_ONE, STEP_IF
	} step_t;

	typedef enum logic [1:0] {
		FLAG_HOLD, FLAG_GE0, FLAG_LE0
	} flag_op_t;

	// Sequencer to datapath
	typedef struct packed {
		mul_sel_t mul_sel;
		logic     ld_a2;
		logic     ld_b2;
		logic     ld_sq;
		acc_op_t  acc_op;
		dec_op_t  dec_op;
		step_t    x_step;
		step_t    y_step;
		flag_op_t flag_op;
		logic     rgn_ld;
		region_t  rgn_val;
		logic     emit;
		logic     idle;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic    start;
		logic    step;
		region_t region;
		logic    ge;
		logic    y_zero;
		logic    out_free;
		logic    emit_last;
	} stat_t;

endpackage

// ----- rtl/mer_item_if.sv -----
// Input channel of the rasterizer: valid/ready plus one item word.
// Depends on mer_pkg for field widths.
interface mer_item_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic signed [mer_pkg::CENTER_W-1:0] center_x;
	logic signed [mer_pkg::CENTER_W-1:0] center_y;
	logic [mer_pkg::SEMI_W-1:0]          semi_axis_x;
	logic [mer_pkg::SEMI_W-1:0]          semi_axis_y;
	logic [mer_pkg::COLOR_W-1:0]         pixel_color;

	modport source (output valid, op, center_x, center_y, semi_axis_x, semi_axis_y,
		pixel_color, input ready);
	modport sink (input valid, op, center_x, center_y, semi_axis_x, semi_axis_y,
		pixel_color, output ready);
endinterface

// ----- rtl/mer_result_if.sv -----
// Output channel of the rasterizer: valid/ready plus one pixel word.
// Depends on mer_pkg for field widths.
interface mer_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [mer_pkg::COORD_W-1:0] pixel_x;
	logic signed [mer_pkg::COORD_W-1:0] pixel_y;
	logic [mer_pkg::COLOR_W-1:0]        color_out;
	logic                               plot;
	logic                               last;
	logic                               finished;

	modport source (output valid, pixel_x, pixel_y, color_out, plot, last, finished,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, color_out, plot, last, finished,
		output ready);
endinterface

// ----- rtl/mer_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on mer_pkg for field widths.
interface mer_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mer_pkg::CFG_IDX_W-1:0] index;
	logic [mer_pkg::ORIGIN_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mer_mul.sv -----
// Shared signed multiplier with operand routing and a registered product.
// Depends on mer_pkg for the operand select codes.
module mer_mul #(
	parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
	input  logic                                 clk,
	input  mer_pkg::mul_sel_t                    sel,
	input  logic [AXIS_BITS-1:0]                 a,
	input  logic [AXIS_BITS-1:0]                 b,
	input  logic [2*AXIS_BITS-1:0]               a2,
	input  logic [2*AXIS_BITS-1:0]               b2,
	input  logic [AXIS_BITS:0]                   x,
	input  logic [AXIS_BITS:0]                   y,
	input  logic [2*AXIS_BITS+3:0]               sq,
	output logic signed [2*(2*AXIS_BITS+5)-1:0]  p_q
);
	localparam int OW = 2*AXIS_BITS + 5;
	localparam int PW = 2*OW;
	localparam logic signed [OW-1:0] K_ONE   = OW'(1);
	localparam logic signed [OW-1:0] K_TWO   = OW'(2);
	localparam logic signed [OW-1:0] K_THREE = OW'(3);

	logic signed [OW-1:0] as, bs, a2s, b2s, xs, ys, sqs;
	logic signed [OW-1:0] opa, opb;

	// Widen every source to the common signed operand width
	always_comb begin
		as  = $signed(OW'(a));
		bs  = $signed(OW'(b));
		a2s = $signed(OW'(a2));
		b2s = $signed(OW'(b2));
		xs  = $signed(OW'(x));
		ys  = $signed(OW'(y));
		sqs = $signed(OW'(sq));
	end

	// Route the operand pair for this step
	always_comb begin
		case (sel)
			mer_pkg::MS_AA: begin
				opa = as;  opb = as;
			end
			mer_pkg::MS_BB: begin
				opa = bs;  opb = bs;
			end
			mer_pkg::MS_A2_INIT: begin
				opa = a2s; opb = K_ONE - (bs <<< 2);
			end
			mer_pkg::MS_B2_X3: begin
				opa = b2s; opb = (xs <<< 1) + K_THREE;
			end
			mer_pkg::MS_A2_2Y: begin
				opa = a2s; opb = K_TWO - (ys <<< 1);
			end
			mer_pkg::MS_A2_3Y: begin
				opa = a2s; opb = K_THREE - (ys <<< 1);
			end
			mer_pkg::MS_B2_X2: begin
				opa = b2s; opb = (xs <<< 1) + K_TWO;
			end
			mer_pkg::MS_B2_X: begin
				opa = b2s; opb = xs;
			end
			mer_pkg::MS_A2_Y: begin
				opa = a2s; opb = ys;
			end
			mer_pkg::MS_TX2: begin
				opa = (xs <<< 1) + K_ONE; opb = (xs <<< 1) + K_ONE;
			end
			mer_pkg::MS_TY2: begin
				opa = ys - K_ONE; opb = ys - K_ONE;
			end
			mer_pkg::MS_B2_SQ: begin
				opa = b2s; opb = sqs;
			end
			mer_pkg::MS_A2_SQ: begin
				opa = a2s; opb = sqs;
			end
			mer_pkg::MS_A2_B2: begin
				opa = a2s; opb = b2s;
			end
			default: begin
				opa = '0;  opb = '0;
			end
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		p_q <= PW'(opa) * PW'(opb);
	end
endmodule

// ----- rtl/mer_ctrl.sv -----
// Sequencer of the rasterizer: walks the multiply/accumulate steps of one item.
// Depends on mer_pkg for the state, status and control types.
module mer_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  mer_pkg::stat_t  stat,
	output mer_pkg::ctrl_t  ctrl
);
	mer_pkg::state_t state_q, state_d;

	// Hold the current step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next step
	always_comb begin
		state_d = state_q;
		case (state_q)
			mer_pkg::ST_IDLE: begin
				if (stat.start) begin
					state_d = mer_pkg::ST_SQA;
				end else if (stat.step && stat.region == mer_pkg::RGN_ONE) begin
					state_d = mer_pkg::ST_R1A;
				end else if (stat.step && stat.region == mer_pkg::RGN_TWO) begin
					state_d = mer_pkg::ST_R2A;
				end
			end
			mer_pkg::ST_SQA:  state_d = mer_pkg::ST_SQB;
			mer_pkg::ST_SQB:  state_d = mer_pkg::ST_INI1;
			mer_pkg::ST_INI1: state_d = mer_pkg::ST_INI2;
			mer_pkg::ST_INI2: state_d = mer_pkg::ST_INI3;
			mer_pkg::ST_INI3: state_d = mer_pkg::ST_CHK1;
			mer_pkg::ST_R1A:  state_d = mer_pkg::ST_R1B;
			mer_pkg::ST_R1B:  state_d = mer_pkg::ST_R1C;
			mer_pkg::ST_R1C:  state_d = mer_pkg::ST_CHK1;
			mer_pkg::ST_R2A:  state_d = mer_pkg::ST_R2B;
			mer_pkg::ST_R2B:  state_d = mer_pkg::ST_R2C;
			mer_pkg::ST_R2C:  state_d = mer_pkg::ST_CHK1;
			mer_pkg::ST_CHK1: begin
				state_d = (stat.region == mer_pkg::RGN_ONE) ? mer_pkg::ST_CHK2
					: mer_pkg::ST_YCHK;
			end
			mer_pkg::ST_CHK2: state_d = mer_pkg::ST_CHK3;
			mer_pkg::ST_CHK3: begin
				state_d = stat.ge ? mer_pkg::ST_Q1 : mer_pkg::ST_EMIT;
			end
			mer_pkg::ST_Q1:    state_d = mer_pkg::ST_Q2;
			mer_pkg::ST_Q2:    state_d = mer_pkg::ST_Q3;
			mer_pkg::ST_Q3:    state_d = mer_pkg::ST_Q4;
			mer_pkg::ST_Q4:    state_d = mer_pkg::ST_Q5;
			mer_pkg::ST_Q5:    state_d = mer_pkg::ST_Q6;
			mer_pkg::ST_Q6:    state_d = mer_pkg::ST_TRUNC;
			mer_pkg::ST_TRUNC: state_d = mer_pkg::ST_YCHK;
			mer_pkg::ST_YCHK:  state_d = mer_pkg::ST_EMIT;
			mer_pkg::ST_EMIT: begin
				if (stat.out_free && stat.emit_last) begin
					state_d = mer_pkg::ST_IDLE;
				end
			end
			default: state_d = mer_pkg::ST_IDLE;
		endcase
	end

	// Datapath controls for each step
	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = mer_pkg::MS_AA;
		ctrl.acc_op  = mer_pkg::ACC_HOLD;
		ctrl.dec_op  = mer_pkg::DEC_HOLD;
		ctrl.x_step  = mer_pkg::STEP_HOLD;
		ctrl.y_step  = mer_pkg::STEP_HOLD;
		ctrl.flag_op = mer_pkg::FLAG_HOLD;
		ctrl.rgn_val = mer_pkg::RGN_ONE;
		case (state_q)
			mer_pkg::ST_IDLE: ctrl.idle = 1'b1;
			mer_pkg::ST_SQA:  ctrl.mul_sel = mer_pkg::MS_AA;
			mer_pkg::ST_SQB: begin
				ctrl.mul_sel = mer_pkg::MS_BB;
				ctrl.ld_a2   = 1'b1;
			end
			mer_pkg::ST_INI1: begin
				ctrl.mul_sel = mer_pkg::MS_A2_INIT;
				ctrl.ld_b2   = 1'b1;
			end
			mer_pkg::ST_INI2: ctrl.acc_op = mer_pkg::ACC_INIT;
			mer_pkg::ST_INI3: ctrl.dec_op = mer_pkg::DEC_TRUNC;
			mer_pkg::ST_R1A:  ctrl.mul_sel = mer_pkg::MS_B2_X3;
			mer_pkg::ST_R1B: begin
				ctrl.dec_op  = mer_pkg::DEC_ADD;
				ctrl.flag_op = mer_pkg::FLAG_GE0;
				ctrl.mul_sel = mer_pkg::MS_A2_2Y;
			end
			mer_pkg::ST_R1C: begin
				ctrl.dec_op = mer_pkg::DEC_ADD_IF;
				ctrl.x_step = mer_pkg::STEP_ONE;
				ctrl.y_step = mer_pkg::STEP_IF;
			end
			mer_pkg::ST_R2A: ctrl.mul_sel = mer_pkg::MS_A2_3Y;
			mer_pkg::ST_R2B: begin
				ctrl.dec_op  = mer_pkg::DEC_ADD;
				ctrl.flag_op = mer_pkg::FLAG_LE0;
				ctrl.mul_sel = mer_pkg::MS_B2_X2;
			end
			mer_pkg::ST_R2C: begin
				ctrl.dec_op = mer_pkg::DEC_ADD_IF;
				ctrl.x_step = mer_pkg::STEP_IF;
				ctrl.y_step = mer_pkg::STEP_ONE;
			end
			mer_pkg::ST_CHK1: ctrl.mul_sel = mer_pkg::MS_B2_X;
			mer_pkg::ST_CHK2: begin
				ctrl.acc_op  = mer_pkg::ACC_LOAD;
				ctrl.mul_sel = mer_pkg::MS_A2_Y;
			end
			mer_pkg::ST_CHK3: ctrl.mul_sel = mer_pkg::MS_TX2;
			mer_pkg::ST_Q1:   ctrl.mul_sel = mer_pkg::MS_TX2;
			mer_pkg::ST_Q2: begin
				ctrl.ld_sq   = 1'b1;
				ctrl.mul_sel = mer_pkg::MS_TY2;
			end
			mer_pkg::ST_Q3: begin
				ctrl.mul_sel = mer_pkg::MS_B2_SQ;
				ctrl.ld_sq   = 1'b1;
			end
			mer_pkg::ST_Q4: begin
				ctrl.acc_op  = mer_pkg::ACC_LOAD_RND;
				ctrl.mul_sel = mer_pkg::MS_A2_SQ;
			end
			mer_pkg::ST_Q5: begin
				ctrl.acc_op  = mer_pkg::ACC_ADD4;
				ctrl.mul_sel = mer_pkg::MS_A2_B2;
			end
			mer_pkg::ST_Q6:   ctrl.acc_op = mer_pkg::ACC_SUB4;
			mer_pkg::ST_TRUNC: begin
				ctrl.dec_op  = mer_pkg::DEC_TRUNC;
				ctrl.rgn_ld  = 1'b1;
				ctrl.rgn_val = mer_pkg::RGN_TWO;
			end
			mer_pkg::ST_YCHK: begin
				ctrl.rgn_ld  = (stat.region == mer_pkg::RGN_TWO) && stat.y_zero;
				ctrl.rgn_val = mer_pkg::RGN_DONE;
			end
			mer_pkg::ST_EMIT: ctrl.emit = stat.out_free;
			default: ctrl.idle = 1'b0;
		endcase
	end
endmodule

// ----- rtl/midpoint_ellipse_raster.sv -----
// Midpoint ellipse rasterizer, one shared multiplier under a step sequencer.
// Start: the axes are squared and the decision is set up before the region test runs;
// a step first updates the decision; a region change adds the region-two set-up.
// Four pixels follow one per cycle unless the result channel stalls; no new item is taken
// until the last one leaves, and a step past the end gives one empty word.
// Reset: origins 640/480, no ellipse loaded (steps report finished), no result pending.
module midpoint_ellipse_raster #(
	parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	mer_item_if.sink          item,
	mer_result_if.source      result,
	mer_cfg_if.sink           cfg
);
	localparam int XW = AXIS_BITS + 1;
	localparam int SW = 2*AXIS_BITS;
	localparam int QW = 2*AXIS_BITS + 4;
	localparam int OW = 2*AXIS_BITS + 5;
	localparam int PW = 2*OW;
	localparam int DW = 4*AXIS_BITS + 6;
	localparam int CW = mer_pkg::COORD_W;
	localparam logic signed [PW-1:0] K_RND = PW'(2);
	localparam logic signed [PW-1:0] K_BIAS = PW'(3);

	// Divide by four, rounding toward zero
	function automatic logic signed [DW-1:0] trunc4(input logic signed [PW-1:0] q);
		logic signed [PW-1:0] r;
		r = q[PW-1] ? q + K_BIAS : q;
		return DW'(r >>> 2);
	endfunction

	mer_pkg::ctrl_t   ctrl;
	mer_pkg::stat_t   stat;
	mer_pkg::region_t region_q;

	logic [mer_pkg::ORIGIN_W-1:0] origin_x_q, origin_y_q;
	logic [CW-1:0]                scx_q, scy_q;
	logic [AXIS_BITS-1:0]         a_q, b_q;
	logic [SW-1:0]                a2_q, b2_q;
	logic [XW-1:0]                x_q, y_q;
	logic [QW-1:0]                sq_q;
	logic signed [DW-1:0]         dec_q;
	logic signed [PW-1:0]         acc_q;
	logic signed [PW-1:0]         p_q;
	logic                         flag_q;
	logic [mer_pkg::COLOR_W-1:0]  color_q;
	logic [1:0]                   k_q;

	logic                         acc_in, start_acc, step_acc, done_acc, out_free;
	logic signed [PW-1:0]         b2_ext;
	logic [CW-1:0]                px, py, xs, ys;

	logic                         ovalid_q, plot_q, last_q, fin_q;
	logic signed [CW-1:0]         px_q, py_q;
	logic [mer_pkg::COLOR_W-1:0]  ocol_q;

	// Handshakes
	assign out_free    = !ovalid_q || result.ready;
	assign item.ready  = ctrl.idle && out_free;
	assign acc_in      = item.valid && item.ready;
	assign start_acc   = acc_in && (item.op == mer_pkg::OP_START);
	assign step_acc    = acc_in && (item.op == mer_pkg::OP_STEP);
	assign done_acc    = step_acc && (region_q == mer_pkg::RGN_DONE);
	assign cfg.ready   = 1'b1;

	// Status toward the sequencer
	always_comb begin
		stat.start     = start_acc;
		stat.step      = step_acc;
		stat.region    = region_q;
		stat.ge        = (acc_q >= p_q);
		stat.y_zero    = (y_q == '0);
		stat.out_free  = out_free;
		stat.emit_last = (k_q == 2'd3);
	end

	mer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mer_mul #(.AXIS_BITS(AXIS_BITS)) u_mul (
		.clk (clk),
		.sel (ctrl.mul_sel),
		.a   (a_q),
		.b   (b_q),
		.a2  (a2_q),
		.b2  (b2_q),
		.x   (x_q),
		.y   (y_q),
		.sq  (sq_q),
		.p_q (p_q)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= mer_pkg::ORIGIN_X_RST;
			origin_y_q <= mer_pkg::ORIGIN_Y_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				mer_pkg::CFG_ORIGIN_X: origin_x_q <= cfg.data;
				mer_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg.data;
				default: origin_x_q <= origin_x_q;
			endcase
		end
	end

	// Region and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= mer_pkg::RGN_DONE;
			k_q      <= 2'd0;
		end else begin
			if (start_acc) begin
				region_q <= mer_pkg::RGN_ONE;
			end else if (ctrl.rgn_ld) begin
				region_q <= ctrl.rgn_val;
			end
			if (ctrl.emit) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	assign b2_ext = $signed(PW'(b2_q));

	// Ellipse parameters, position and decision variable
	always_ff @(posedge clk) begin
		if (start_acc) begin
			scx_q   <= CW'(origin_x_q) + CW'(item.center_x);
			scy_q   <= CW'(origin_y_q) - CW'(item.center_y);
			a_q     <= AXIS_BITS'(item.semi_axis_x);
			b_q     <= AXIS_BITS'(item.semi_axis_y);
			color_q <= item.pixel_color;
			x_q     <= '0;
			y_q     <= XW'(AXIS_BITS'(item.semi_axis_y));
		end else begin
			case (ctrl.x_step)
				mer_pkg::STEP_ONE: x_q <= x_q + XW'(1);
				mer_pkg::STEP_IF:  x_q <= flag_q ? x_q + XW'(1) : x_q;
				default:           x_q <= x_q;
			endcase
			case (ctrl.y_step)
				mer_pkg::STEP_ONE: y_q <= y_q - XW'(1);
				mer_pkg::STEP_IF:  y_q <= flag_q ? y_q - XW'(1) : y_q;
				default:           y_q <= y_q;
			endcase
		end
		if (ctrl.ld_a2) begin
			a2_q <= p_q[SW-1:0];
		end
		if (ctrl.ld_b2) begin
			b2_q <= p_q[SW-1:0];
		end
		if (ctrl.ld_sq) begin
			sq_q <= p_q[QW-1:0];
		end
		// Quarter-unit accumulator
		case (ctrl.acc_op)
			mer_pkg::ACC_INIT:     acc_q <= p_q + (b2_ext <<< 2) + K_RND;
			mer_pkg::ACC_LOAD:     acc_q <= p_q;
			mer_pkg::ACC_LOAD_RND: acc_q <= p_q + K_RND;
			mer_pkg::ACC_ADD4:     acc_q <= acc_q + (p_q <<< 2);
			mer_pkg::ACC_SUB4:     acc_q <= acc_q - (p_q <<< 2);
			default:               acc_q <= acc_q;
		endcase
		// Decision variable
		case (ctrl.dec_op)
			mer_pkg::DEC_ADD:    dec_q <= dec_q + $signed(p_q[DW-1:0]);
			mer_pkg::DEC_ADD_IF: dec_q <= flag_q ? dec_q + $signed(p_q[DW-1:0]) : dec_q;
			mer_pkg::DEC_TRUNC:  dec_q <= trunc4(acc_q);
			default:             dec_q <= dec_q;
		endcase
		// Sign test of the decision before its update
		case (ctrl.flag_op)
			mer_pkg::FLAG_GE0: flag_q <= !dec_q[DW-1];
			mer_pkg::FLAG_LE0: flag_q <= dec_q[DW-1] || (dec_q == '0);
			default:           flag_q <= flag_q;
		endcase
	end

	// Mirrored pixel for the current counter value
	always_comb begin
		xs = CW'(x_q);
		ys = CW'(y_q);
		px = k_q[1] ? scx_q - xs : scx_q + xs;
		py = k_q[0] ? scy_q - ys : scy_q + ys;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctrl.emit || done_acc) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			px_q   <= $signed(px);
			py_q   <= $signed(py);
			ocol_q <= color_q;
			plot_q <= 1'b1;
			last_q <= (k_q == 2'd3);
			fin_q  <= (region_q == mer_pkg::RGN_DONE);
		end else if (done_acc) begin
			px_q   <= '0;
			py_q   <= '0;
			ocol_q <= '0;
			plot_q <= 1'b0;
			last_q <= 1'b1;
			fin_q  <= 1'b1;
		end
	end

	assign result.valid     = ovalid_q;
	assign result.pixel_x   = px_q;
	assign result.pixel_y   = py_q;
	assign result.color_out = ocol_q;
	assign result.plot      = plot_q;
	assign result.last      = last_q;
	assign result.finished  = fin_q;

	// An empty result always closes the item and reports the ellipse done
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.plot |-> result.last && result.finished)
		else $error("empty word without last/finished");

	// The four pixels of one item leave without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.plot && !result.last |=> result.valid)
		else $error("gap inside a pixel burst");

	// A start keeps the block busy for the following cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc |=> !item.ready)
		else $error("ready right after a start");

	// A finished ellipse stays finished until the next start
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		region_q == mer_pkg::RGN_DONE && !start_acc |=> region_q == mer_pkg::RGN_DONE)
		else $error("region left done without a start");
endmodule

// ----- bench/mer_raster_checker.sv -----
// Scoreboard for the midpoint ellipse rasterizer: follows the ellipse walk for every
// accepted item word and checks each pixel word that leaves the block.
// Depends on mer_pkg and the item, result and configuration channel interfaces.
module mer_raster_checker (
	input  logic  clk,
	input  logic  arst_n,
	mer_item_if   item,
	mer_result_if result,
	mer_cfg_if    cfg,
	output int    fail_count,
	output int    pending,
	output int    pixels_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import mer_pkg::*;

	typedef struct {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [COLOR_W-1:0] color;
		logic               plot;
		logic               last;
		logic               finished;
	} pixel_word_t;

	pixel_word_t pending_pixels[$];

	// Shadow of the block: origins, screen centre, squared axes, walk point, decision
	logic [ORIGIN_W-1:0] org_x, org_y;
	longint              ctr_x, ctr_y, asq, bsq, walk_x, walk_y, dvar;
	region_t             rgn;
	logic [COLOR_W-1:0]  ink;

	function automatic logic [COORD_W-1:0] screen_coord(input longint v);
		logic [63:0] w;
		w = v;
		return w[COORD_W-1:0];
	endfunction

	// Leave region one once the slope passes -1; finish region two at the x axis
	function automatic void settle_region();
		longint tx, ty;
		if (rgn == RGN_ONE && bsq * walk_x >= asq * walk_y) begin
			tx = 2 * walk_x + 1;
			ty = walk_y - 1;
			dvar = (bsq * tx * tx + 4 * asq * ty * ty - 4 * asq * bsq + 2) / 4;
			rgn = RGN_TWO;
		end
		if (rgn == RGN_TWO && walk_y <= 0)
			rgn = RGN_DONE;
	endfunction

	// Queue the four mirror images of the walk point
	function automatic void push_mirrors();
		pixel_word_t w;
		for (int k = 0; k < 4; k++) begin
			w.px = screen_coord(k < 2 ? ctr_x + walk_x : ctr_x - walk_x);
			w.py = screen_coord(k[0] ? ctr_y - walk_y : ctr_y + walk_y);
			w.color = ink;
			w.plot = 1'b1;
			w.last = (k == 3);
			w.finished = (rgn == RGN_DONE);
			pending_pixels.push_back(w);
		end
	endfunction

	function automatic void load_ellipse(input logic signed [CENTER_W-1:0] cx,
			input logic signed [CENTER_W-1:0] cy, input logic [SEMI_W-1:0] sa,
			input logic [SEMI_W-1:0] sb, input logic [COLOR_W-1:0] c);
		longint a, b;
		a = longint'(sa) & ((longint'(1) << AXIS_BITS_DEF) - 1);
		b = longint'(sb) & ((longint'(1) << AXIS_BITS_DEF) - 1);
		ctr_x = longint'(org_x) + longint'(cx);
		ctr_y = longint'(org_y) - longint'(cy);
		asq = a * a;
		bsq = b * b;
		ink = c;
		walk_x = 0;
		walk_y = b;
		// b^2 + a^2 (1/4 - b) + 1/2, counted in quarters and truncated
		dvar = (4 * bsq + asq * (1 - 4 * b) + 2) / 4;
		rgn = RGN_ONE;
		settle_region();
		push_mirrors();
	endfunction

	function automatic void advance_ellipse();
		pixel_word_t w;
		longint before_add;
		case (rgn)
			RGN_ONE: begin
				before_add = dvar;
				dvar += bsq * (2 * walk_x + 3);
				if (before_add >= 0) begin
					dvar += asq * (2 - 2 * walk_y);
					walk_y--;
				end
				walk_x++;
			end
			RGN_TWO: begin
				if (dvar > 0) begin
					dvar += asq * (3 - 2 * walk_y);
				end else begin
					dvar += bsq * (2 * walk_x + 2) + asq * (3 - 2 * walk_y);
					walk_x++;
				end
				walk_y--;
			end
			default: begin
				// nothing left to draw: one empty word that closes the item
				w.px = '0;
				w.py = '0;
				w.color = '0;
				w.plot = 1'b0;
				w.last = 1'b1;
				w.finished = 1'b1;
				pending_pixels.push_back(w);
				return;
			end
		endcase
		settle_region();
		push_mirrors();
	endfunction

	function automatic bit field_ok(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got === want)
			return 1'b1;
		$display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_word_t want;
		bit ok;
		if (!arst_n) begin
			org_x = ORIGIN_X_RST;
			org_y = ORIGIN_Y_RST;
			ctr_x = 0;
			ctr_y = 0;
			asq = 0;
			bsq = 0;
			walk_x = 0;
			walk_y = 0;
			dvar = 0;
			rgn = RGN_DONE;
			ink = '0;
			pending_pixels.delete();
			fail_count = 0;
			pixels_seen = 0;
		end else begin
			// check the pixel word leaving the block against the oldest prediction
			if (result.valid && result.ready) begin
				pixels_seen++;
				if (pending_pixels.size() == 0) begin
					$display("%0t ns: pixel word with none expected: x 'h%0h y 'h%0h plot %0b",
						$time, result.pixel_x, result.pixel_y, result.plot);
					fail_count++;
				end else begin
					want = pending_pixels.pop_front();
					ok = 1'b1;
					ok &= field_ok("pixel_x", {want.px}, {result.pixel_x});
					ok &= field_ok("pixel_y", {want.py}, {result.pixel_y});
					ok &= field_ok("color_out", {want.color}, {result.color_out});
					ok &= field_ok("plot", {want.plot}, {result.plot});
					ok &= field_ok("last", {want.last}, {result.last});
					ok &= field_ok("finished", {want.finished}, {result.finished});
					if (!ok)
						fail_count++;
				end
			end

			// track origin writes; other indexes are dropped
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ORIGIN_X: org_x = cfg.data;
					CFG_ORIGIN_Y: org_y = cfg.data;
					default: ;
				endcase
			end

			if (item.valid && item.ready) begin
				if (item.op == OP_START)
					load_ellipse(item.center_x, item.center_y, item.semi_axis_x,
						item.semi_axis_y, item.pixel_color);
				else
					advance_ellipse();
			end
		end
		pending = pending_pixels.size();
	end

endmodule

// ----- bench/tb_midpoint_ellipse_raster.sv -----
// Top of the rasterizer bench: clock, reset, item and register stimulus under four
// pacing phases, random result back-pressure and the final verdict.
// Depends on mer_pkg, the channel interfaces, midpoint_ellipse_raster and mer_raster_checker.
module tb_midpoint_ellipse_raster;
	timeunit 1ns;
	timeprecision 1ps;
	import mer_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int SETTLE_CYCLES   = 40;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int DRAIN_LIMIT     = 100000;

	logic clk;
	logic arst_n;
	int   idle_pct, stall_pct;
	int   fail_count, pending, pixels_seen;
	int   starts_sent, steps_sent, reg_writes;

	mer_item_if   item();
	mer_result_if result();
	mer_cfg_if    cfg();

	midpoint_ellipse_raster i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	mer_raster_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.pending     (pending),
		.pixels_seen (pixels_seen)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		result.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Offer one item word, idling first at random; returns at the negedge after acceptance
	task automatic send_word(input logic op, input logic signed [CENTER_W-1:0] cx,
			input logic signed [CENTER_W-1:0] cy, input logic [SEMI_W-1:0] sa,
			input logic [SEMI_W-1:0] sb, input logic [COLOR_W-1:0] c);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid <= 1'b1;
		item.op <= op;
		item.center_x <= cx;
		item.center_y <= cy;
		item.semi_axis_x <= sa;
		item.semi_axis_y <= sb;
		item.pixel_color <= c;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_START)
			starts_sent++;
		else
			steps_sent++;
	endtask

	// Step word; the start-only fields carry noise
	task automatic step_word();
		logic [63:0] n;
		n = {$urandom, $urandom};
		send_word(OP_STEP, n[10:0], n[21:11], n[30:22], n[39:31], n[63:40]);
	endtask

	// Mostly small ellipses walked to the end and a little past; some wide ones cut short
	task automatic random_ellipse();
		logic [63:0] n;
		int a, b, steps;
		n = {$urandom, $urandom};
		if ($urandom_range(0, 4) == 0) begin
			a = $urandom_range(0, 511);
			b = $urandom_range(0, 511);
			steps = $urandom_range(1, 20);
		end else begin
			a = $urandom_range(0, 14);
			b = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0)
				steps = $urandom_range(0, a + b + 1);
			else
				steps = a + b + 2 + $urandom_range(0, 2);
		end
		send_word(OP_START, n[10:0], n[21:11], a[8:0], b[8:0], n[63:40]);
		repeat (steps)
			step_word();
	endtask

	// Write one register; the caller drops valid after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ORIGIN_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		reg_writes++;
	endtask

	// Hold until every predicted word has left, then let the block settle
	task automatic drain();
		int guard;
		guard = 0;
		while (pending != 0 && guard < DRAIN_LIMIT) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		int first;
		logic [31:0] r;
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.op = OP_STEP;
		item.center_x = '0;
		item.center_y = '0;
		item.semi_axis_x = '0;
		item.semi_axis_y = '0;
		item.pixel_color = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_ORIGIN_X;
		cfg.data = '0;
		result.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		starts_sent = 0;
		steps_sent = 0;
		reg_writes = 0;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			// set pacing and origins while the block is idle
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 76;
					stall_pct = 0;
					write_reg(CFG_ORIGIN_X, 11'd0);
					write_reg(CFG_ORIGIN_Y, 11'd2047);
				end
				2: begin
					idle_pct = 0;
					stall_pct = 76;
					r = $urandom;
					write_reg(CFG_SPARE_LO, r[10:0]);
					write_reg(CFG_ORIGIN_X, 11'd2047);
					write_reg(CFG_SPARE_HI, r[21:11]);
					write_reg(CFG_ORIGIN_Y, 11'd0);
				end
				default: begin
					idle_pct = 25;
					stall_pct = 25;
					r = $urandom;
					write_reg(CFG_ORIGIN_X, r[10:0]);
					write_reg(CFG_ORIGIN_Y, r[21:11]);
				end
			endcase
			if (ph != 0)
				cfg.valid <= 1'b0;

			first = starts_sent + steps_sent;
			if (ph == 0) begin
				// step with no ellipse loaded
				step_word();
				// point ellipse, finished at once
				send_word(OP_START, 11'h000, 11'h000, 9'd0, 9'd0, 24'h123456);
				step_word();
				// widest axes at the far corners of the centre range
				send_word(OP_START, 11'h400, 11'h3FF, 9'd511, 9'd511, 24'hFFFFFF);
				repeat (2)
					step_word();
				send_word(OP_START, 11'h3FF, 11'h400, 9'd1, 9'd511, 24'h000000);
				repeat (2)
					step_word();
				// small ellipse through the region change
				send_word(OP_START, 11'h005, 11'h7F9, 9'd3, 9'd2, 24'hA5A5A5);
				repeat (5)
					step_word();
				// zero horizontal axis: region two from the start
				send_word(OP_START, 11'h7FD, 11'h002, 9'd0, 9'd5, 24'h5A5A5A);
				repeat (6)
					step_word();
				// zero vertical axis: done on the start word
				send_word(OP_START, 11'h009, 11'h000, 9'd5, 9'd0, 24'h00FF00);
				step_word();
			end
			while (starts_sent + steps_sent - first < ITEMS_PER_PHASE)
				random_ellipse();
			item.valid <= 1'b0;
			drain();
		end

		if (pending != 0)
			$display("%0t ns: %0d pixel words never arrived", $time, pending);
		$display("Covered %0d ellipse starts and %0d steps over four pacing phases,",
			starts_sent, steps_sent);
		$display("with %0d register writes and %0d pixel words checked.", reg_writes, pixels_seen);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("%0t ns: run did not complete in time", $time);
		$display("simulation failed");
		$finish;
	end

endmodule

// ----- midpoint_ellipse_raster.f -----
rtl/mer_pkg.sv
rtl/mer_item_if.sv
rtl/mer_result_if.sv
rtl/mer_cfg_if.sv
rtl/mer_mul.sv
rtl/mer_ctrl.sv
rtl/midpoint_ellipse_raster.sv
bench/mer_raster_checker.sv
bench/tb_midpoint_ellipse_raster.sv
